/* hw/rtl/double_ended_priority_queue_top_assert.svh */
// Assertion macros for the double-ended priority queue.
// Included by double_ended_priority_queue_top.sv; no other dependencies.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dpq assertion failed");
`define DPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpq assertion failed");
`else
`define DPQ_ASSERT(lbl, clk, rst_n, prop)
`define DPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/dpq_pkg.sv */
// Shared types, sizes and codes of the double-ended priority queue.
// No dependencies.
package dpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_W     = 24;
    localparam int PRI_W    = 24;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int GRP_LOG  = ($clog2(CAPACITY) + 1) / 2;
    localparam int GROUP    = 1 << GRP_LOG;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_MAX = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_MIN = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUP   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic   cmp;
        logic   shift_ins;
        logic   shift_out;
        entry_t data;
    } cmd_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
    } probe_t;

endpackage

/* hw/rtl/dpq_req_if.sv */
// Request channel of the double-ended priority queue.
// Depends on dpq_pkg.
interface dpq_req_if;
    logic                        valid;
    logic                        ready;
    logic [dpq_pkg::OP_W-1:0]    opcode;
    logic [dpq_pkg::ID_W-1:0]    client_id;
    logic [dpq_pkg::PRI_W-1:0]   priority_req;

    modport source (output valid, output opcode, output client_id, output priority_req,
                    input ready);
    modport sink (input valid, input opcode, input client_id, input priority_req,
                  output ready);
endinterface

/* hw/rtl/dpq_rsp_if.sv */
// Result channel of the double-ended priority queue.
// Depends on dpq_pkg.
interface dpq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dpq_pkg::ID_W-1:0]    served_id;
    logic [dpq_pkg::STAT_W-1:0]  status;

    modport source (output valid, output served_id, output status, input ready);
    modport sink (input valid, input served_id, input status, output ready);
endinterface

/* hw/rtl/dpq_cell.sv */
// One cell of the sorted chain: holds one entry and its compare flag.
// Depends on dpq_pkg.
module dpq_cell (
    input  logic                clk,
    input  logic                occupied,
    input  logic                top,
    input  dpq_pkg::cmd_t       cmd,
    input  dpq_pkg::entry_t     left_entry,
    input  logic                left_lt,
    input  dpq_pkg::entry_t     right_entry,
    output dpq_pkg::entry_t     entry,
    output logic                lt,
    output dpq_pkg::probe_t     probe
);

    dpq_pkg::entry_t entry_reg;
    dpq_pkg::entry_t entry_next;
    logic            lt_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift_ins && !lt_reg)
        begin
            entry_next = left_lt ? cmd.data : left_entry;
        end
        else if (cmd.shift_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.cmp)
        begin
            lt_reg <= occupied && (entry_reg.pri < cmd.data.pri);
        end
    end

    assign probe.hit = occupied && (entry_reg.pri == cmd.data.pri);
    assign probe.id  = top ? entry_reg.id : '0;
    assign entry     = entry_reg;
    assign lt        = lt_reg;

endmodule

/* hw/rtl/double_ended_priority_queue_top.sv */
// Double-ended priority queue top level: request and result channels, chain of cells.
// Depends on dpq_pkg, dpq_req_if, dpq_rsp_if, dpq_cell and the assertion header.
//
// Usage:
//   req carries one item per handshake: opcode (insert, pop max, pop min),
//   client_id and priority_req. rsp returns one item per request:
//   served_id and status (ok, empty, full, duplicate).
//   Entries sit in a chain of cells sorted by ascending priority. Each item
//   goes through these steps in order: accept, broadcast compare into every cell,
//   a two-level registered OR tree over groups of cells (duplicate hit, top cell's
//   id), then the apply step that shifts the chain and loads the result register.
//   A new request is taken once the previous item has been applied.
//   Pop min takes cell 0 and shifts the chain down; pop max takes the cell
//   below the occupancy count; insert shifts the cells above its place up.
//   Reset clears the occupancy count; cell contents need no clearing.
//   When rsp stalls, the finished item holds in the result register while
//   the next request is accepted and processed up to its apply step, which
//   waits for the register to free.
module double_ended_priority_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    dpq_req_if.sink        req,
    dpq_rsp_if.source      rsp
);

    `include "double_ended_priority_queue_top_assert.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_RED   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    localparam int PAD = dpq_pkg::NGROUP * dpq_pkg::GROUP;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [dpq_pkg::CNT_W-1:0]      count_reg;
    logic [dpq_pkg::CNT_W-1:0]      count_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [dpq_pkg::ID_W-1:0]       out_id_reg;
    logic [dpq_pkg::ID_W-1:0]       out_id_next;
    logic [dpq_pkg::STAT_W-1:0]     out_stat_reg;
    logic [dpq_pkg::STAT_W-1:0]     out_stat_next;
    logic [dpq_pkg::OP_W-1:0]       op_reg;
    dpq_pkg::entry_t                data_reg;
    logic                           dup_reg;
    logic [dpq_pkg::ID_W-1:0]       top_id_reg;

    logic                           in_fire;
    logic                           apply_go;
    logic                           empty;
    logic                           full;
    dpq_pkg::cmd_t                  cmd;

    dpq_pkg::entry_t                ent   [dpq_pkg::CAPACITY];
    logic                           lt_v  [dpq_pkg::CAPACITY];
    dpq_pkg::probe_t                probe [dpq_pkg::CAPACITY];
    dpq_pkg::probe_t                flat  [PAD];
    dpq_pkg::probe_t                grp_reg  [dpq_pkg::NGROUP];
    dpq_pkg::probe_t                grp_next [dpq_pkg::NGROUP];
    dpq_pkg::probe_t                all_or;

    assign in_fire  = req.valid && req.ready;
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == dpq_pkg::CAP_CNT);

    assign cmd.cmp       = (state_reg == S_CMP);
    assign cmd.shift_ins = apply_go && (op_reg == dpq_pkg::OP_INSERT) && !full && !dup_reg;
    assign cmd.shift_out = apply_go && (op_reg == dpq_pkg::OP_POP_MIN) && !empty;
    assign cmd.data      = data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < dpq_pkg::CAPACITY; gi++)
        begin : g_cell
            dpq_cell u_cell (
                .clk         (clk),
                .occupied    (dpq_pkg::CNT_W'(gi) < count_reg),
                .top         (dpq_pkg::CNT_W'(gi + 1) == count_reg),
                .cmd         (cmd),
                .left_entry  ((gi == 0) ? data_reg : ent[(gi == 0) ? 0 : gi - 1]),
                .left_lt     ((gi == 0) ? 1'b1 : lt_v[(gi == 0) ? 0 : gi - 1]),
                .right_entry (ent[(gi == dpq_pkg::CAPACITY - 1) ? gi : gi + 1]),
                .entry       (ent[gi]),
                .lt          (lt_v[gi]),
                .probe       (probe[gi])
            );
        end
        for (gi = 0; gi < PAD; gi++)
        begin : g_flat
            if (gi < dpq_pkg::CAPACITY)
            begin : g_used
                assign flat[gi] = probe[gi];
            end
            else
            begin : g_pad
                assign flat[gi] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < dpq_pkg::NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < dpq_pkg::GROUP; j++)
            begin
                grp_next[g] = grp_next[g] | flat[g * dpq_pkg::GROUP + j];
            end
        end
        all_or = '0;
        for (int g = 0; g < dpq_pkg::NGROUP; g++)
        begin
            all_or = all_or | grp_reg[g];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_CMP;
            S_CMP:   state_next = S_RED;
            S_RED:   state_next = S_APPLY;
            S_APPLY: if (apply_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        out_id_next   = out_id_reg;
        out_stat_next = out_stat_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (apply_go)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_stat_next  = dpq_pkg::STAT_OK;
            case (op_reg)
                dpq_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        out_stat_next = dpq_pkg::STAT_FULL;
                    end
                    else if (dup_reg)
                    begin
                        out_stat_next = dpq_pkg::STAT_DUP;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                dpq_pkg::OP_POP_MAX:
                begin
                    if (empty)
                    begin
                        out_stat_next = dpq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        out_id_next = top_id_reg;
                        count_next  = count_reg - 1'b1;
                    end
                end
                dpq_pkg::OP_POP_MIN:
                begin
                    if (empty)
                    begin
                        out_stat_next = dpq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        out_id_next = ent[0].id;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    out_stat_next = dpq_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_id_reg   <= out_id_next;
        out_stat_reg <= out_stat_next;
        if (in_fire)
        begin
            op_reg       <= req.opcode;
            data_reg.id  <= req.client_id;
            data_reg.pri <= req.priority_req;
        end
        if (state_reg == S_CMP)
        begin
            for (int g = 0; g < dpq_pkg::NGROUP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (state_reg == S_RED)
        begin
            dup_reg    <= all_or.hit;
            top_id_reg <= all_or.id;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.served_id = out_id_reg;
    assign rsp.status    = out_stat_reg;

    `DPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= dpq_pkg::CAP_CNT)
    `DPQ_ASSERT_NEXT(a_count_hold, clk, rst_n, !apply_go, $stable(count_reg))
    `DPQ_ASSERT_NEXT(a_apply_out, clk, rst_n, apply_go, out_valid_reg)
    `DPQ_ASSERT(a_ready_idle, clk, rst_n, !(req.ready && state_reg == S_APPLY))

endmodule

/* tb/tb.sv */
// Self-checking testbench for double_ended_priority_queue_top.
// Uses dpq_pkg, dpq_req_if and dpq_rsp_if from the RTL and keeps its own sorted copy of the
// queue, so each served id and status is predicted when its request is accepted.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dpq_pkg::ID_W-1:0]   id;
        logic [dpq_pkg::STAT_W-1:0] st;
    } served_t;

    logic clk;
    logic rst_n;

    dpq_req_if req();
    dpq_rsp_if rsp();

    double_ended_priority_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    dpq_pkg::entry_t held_entries[$];
    served_t         pending_served[$];
    int              errors = 0;
    int              burst_left;
    int              burst_max;
    int              gap_max;
    bit              sending;
    int              ready_mode = 0;
    int              ready_left = 0;

    always #5 clk = ~clk;

    function automatic served_t serve_request(input logic [dpq_pkg::OP_W-1:0] op,
                                              input logic [dpq_pkg::ID_W-1:0] id,
                                              input logic [dpq_pkg::PRI_W-1:0] pri);
        served_t         r;
        dpq_pkg::entry_t e;
        int              pos;
        r.id = '0;
        r.st = dpq_pkg::STAT_OK;
        pos = 0;
        case (op)
            dpq_pkg::OP_INSERT:
            begin
                if (held_entries.size() >= dpq_pkg::CAPACITY)
                begin
                    r.st = dpq_pkg::STAT_FULL;
                end
                else
                begin
                    while (pos < held_entries.size() && held_entries[pos].pri < pri)
                        pos++;
                    if (pos < held_entries.size() && held_entries[pos].pri == pri)
                    begin
                        r.st = dpq_pkg::STAT_DUP;
                    end
                    else
                    begin
                        e.id = id;
                        e.pri = pri;
                        held_entries.insert(pos, e);
                    end
                end
            end
            dpq_pkg::OP_POP_MAX:
            begin
                if (held_entries.size() == 0)
                begin
                    r.st = dpq_pkg::STAT_EMPTY;
                end
                else
                begin
                    e = held_entries.pop_back();
                    r.id = e.id;
                end
            end
            dpq_pkg::OP_POP_MIN:
            begin
                if (held_entries.size() == 0)
                begin
                    r.st = dpq_pkg::STAT_EMPTY;
                end
                else
                begin
                    e = held_entries.pop_front();
                    r.id = e.id;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [dpq_pkg::OP_W-1:0] op,
                             input logic [dpq_pkg::ID_W-1:0] id,
                             input logic [dpq_pkg::PRI_W-1:0] pri);
        req.valid <= 1'b1;
        req.opcode <= op;
        req.client_id <= id;
        req.priority_req <= pri;
        sending = 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_served.push_back(serve_request(op, id, pri));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req.valid <= 1'b0;
            req.client_id <= dpq_pkg::ID_W'($urandom);
            req.priority_req <= dpq_pkg::PRI_W'($urandom);
            sending = 1'b0;
            repeat ($urandom_range(1, gap_max))
                @(posedge clk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    task automatic wait_idle();
        if (sending)
        begin
            req.valid <= 1'b0;
            sending = 1'b0;
        end
        @(posedge clk);
        while (pending_served.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_pops();
        send_item(dpq_pkg::OP_POP_MAX, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MIN, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    task automatic test_extremes();
        send_item(dpq_pkg::OP_INSERT, 24'hFFFFFF, 24'h000000);
        send_item(dpq_pkg::OP_INSERT, 24'h000000, 24'hFFFFFF);
        send_item(dpq_pkg::OP_INSERT, 24'hAAAAAA, 24'h555555);
        send_item(dpq_pkg::OP_INSERT, 24'h555555, 24'hAAAAAA);
        send_item(dpq_pkg::OP_INSERT, 24'h123456, 24'h000000);
        send_item(dpq_pkg::OP_INSERT, 24'hABCDEF, 24'hFFFFFF);
        send_item(dpq_pkg::OP_INSERT, 24'h000001, 24'h800000);
        send_item(dpq_pkg::OP_POP_MAX, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MIN, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MIN, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MAX, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MAX, 24'h000000, 24'h000000);
        send_item(dpq_pkg::OP_POP_MIN, 24'h000000, 24'h000000);
    endtask

    task automatic test_fill_to_capacity();
        logic [dpq_pkg::PRI_W-1:0] pri;
        for (int i = 0; i < dpq_pkg::CAPACITY; i++)
        begin
            pri = dpq_pkg::PRI_W'(i * 40503 + 12345);
            send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom), pri);
        end
        send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom), 24'hFFFFFE);
        send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom), held_entries[0].pri);
        for (int i = 0; i < 40; i++)
        begin
            case ($urandom_range(0, 3))
                0: send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom),
                             dpq_pkg::PRI_W'($urandom));
                1: send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom),
                             held_entries[$urandom_range(0, held_entries.size() - 1)].pri);
                2: send_item(dpq_pkg::OP_POP_MAX, dpq_pkg::ID_W'($urandom),
                             dpq_pkg::PRI_W'($urandom));
                default: send_item(dpq_pkg::OP_POP_MIN, dpq_pkg::ID_W'($urandom),
                                   dpq_pkg::PRI_W'($urandom));
            endcase
        end
        while (held_entries.size() != 0)
            send_item($urandom_range(0, 1) ? dpq_pkg::OP_POP_MAX : dpq_pkg::OP_POP_MIN,
                      dpq_pkg::ID_W'($urandom), dpq_pkg::PRI_W'($urandom));
        send_item(dpq_pkg::OP_POP_MIN, dpq_pkg::ID_W'($urandom), dpq_pkg::PRI_W'($urandom));
    endtask

    task automatic test_random_traffic();
        int                        pri_shape;
        int                        ins_pct;
        int                        roll;
        logic [dpq_pkg::PRI_W-1:0] pri;
        for (int seg = 0; seg < 7; seg++)
        begin
            case ($urandom_range(0, 2))
                0: burst_max = 0;
                1: burst_max = 4;
                default: burst_max = 60;
            endcase
            gap_max = $urandom_range(1, 8);
            pri_shape = $urandom_range(0, 2);
            for (int i = 0; i < 100; i++)
            begin
                if (held_entries.size() < 8)
                    ins_pct = 70;
                else if (held_entries.size() > 200)
                    ins_pct = 30;
                else
                    ins_pct = 52;
                roll = $urandom_range(0, 99);
                case (pri_shape)
                    0: pri = dpq_pkg::PRI_W'($urandom);
                    1: pri = dpq_pkg::PRI_W'($urandom_range(0, 31));
                    default: pri = dpq_pkg::PRI_W'(24'hFFFFFF - $urandom_range(0, 31));
                endcase
                if (roll < ins_pct)
                begin
                    if (held_entries.size() != 0 && $urandom_range(0, 9) == 0)
                        pri = held_entries[$urandom_range(0, held_entries.size() - 1)].pri;
                    send_item(dpq_pkg::OP_INSERT, dpq_pkg::ID_W'($urandom), pri);
                end
                else if (roll % 2 == 0)
                begin
                    send_item(dpq_pkg::OP_POP_MAX, dpq_pkg::ID_W'($urandom), pri);
                end
                else
                begin
                    send_item(dpq_pkg::OP_POP_MIN, dpq_pkg::ID_W'($urandom), pri);
                end
            end
            if (seg == 2)
                wait_idle();
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(8, 80);
        end
        else
        begin
            ready_left--;
        end
        case (ready_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_result
        served_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_served.size() == 0)
            begin
                $display("%0t: result with no request waiting: served_id %h status %0d",
                         $time, rsp.served_id, rsp.status);
                errors++;
            end
            else
            begin
                want = pending_served.pop_front();
                if (rsp.served_id !== want.id)
                begin
                    $display("%0t: served_id expected %h actual %h", $time, want.id,
                             rsp.served_id);
                    errors++;
                end
                if (rsp.status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st,
                             rsp.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        burst_left = 0;
        burst_max = 6;
        gap_max = 4;
        sending = 1'b0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.opcode <= dpq_pkg::OP_INSERT;
        req.client_id <= '0;
        req.priority_req <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pops();
        test_extremes();
        wait_idle();
        burst_max = 80;
        gap_max = 3;
        test_fill_to_capacity();
        wait_idle();
        test_random_traffic();
        wait_idle();
        repeat (20)
            @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dpq_pkg.sv
hw/rtl/dpq_req_if.sv
hw/rtl/dpq_rsp_if.sv
hw/rtl/dpq_cell.sv
hw/rtl/double_ended_priority_queue_top.sv
tb/tb.sv
